[sv/usd_pkg.sv]
// usd_pkg: beat types and byte-class constants for the strict utf-8 decoder
// no dependencies; used by every module of the decoder
package usd_pkg;

	localparam int CpWidth = 21;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic               has_char;
		logic               invalid;
		logic               end_of_text;
	} char_beat_t;

	// result of the decode step, before the output register
	typedef struct packed {
		logic       valid;
		char_beat_t beat;
	} usd_res_t;

	// lead byte classes
	localparam logic [7:0] Lead2Mask  = 8'hE0;
	localparam logic [7:0] Lead2Match = 8'hC0;
	localparam logic [7:0] Lead3Mask  = 8'hF0;
	localparam logic [7:0] Lead3Match = 8'hE0;
	localparam logic [7:0] Lead4Mask  = 8'hF8;
	localparam logic [7:0] Lead4Match = 8'hF0;
	localparam logic [7:0] ContMask   = 8'hC0;
	localparam logic [7:0] ContMatch  = 8'h80;

	// code point limits
	localparam logic [CpWidth-1:0] Min2Byte  = 21'h00080;
	localparam logic [CpWidth-1:0] Min3Byte  = 21'h00800;
	localparam logic [CpWidth-1:0] Min4Byte  = 21'h10000;
	localparam logic [CpWidth-1:0] MaxCp     = 21'h10FFFF;
	localparam logic [CpWidth-1:0] SurrLow   = 21'h0D800;
	localparam logic [CpWidth-1:0] SurrHigh  = 21'h0DFFF;

	// continuation count of a sequence
	localparam logic [1:0] Len1 = 2'd1;
	localparam logic [1:0] Len2 = 2'd2;
	localparam logic [1:0] Len3 = 2'd3;

endpackage

[sv/usd_core.sv]
// usd_core: sequence state and combinational byte decode
// depends on usd_pkg
module usd_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  usd_pkg::byte_beat_t beat,
	output usd_pkg::usd_res_t   res
);

	logic [usd_pkg::CpWidth-1:0] partial_q, partial_d;
	logic [1:0]                  pending_q, pending_d;
	logic [1:0]                  seqlen_q, seqlen_d;
	logic                        failed_q, failed_d;

	logic                        err;
	logic                        done;
	logic [usd_pkg::CpWidth-1:0] cp;
	logic [usd_pkg::CpWidth-1:0] merged;
	logic [1:0]                  pend_dec;
	logic                        value_ok;
	logic [7:0]                  b;

	assign b        = beat.data_byte;
	assign merged   = {partial_q[usd_pkg::CpWidth-7:0], b[5:0]};
	assign pend_dec = pending_q - 2'd1;

	always_comb begin
		value_ok = 1'b1;
		if (seqlen_q == usd_pkg::Len1 && merged < usd_pkg::Min2Byte) value_ok = 1'b0;
		if (seqlen_q == usd_pkg::Len2 && merged < usd_pkg::Min3Byte) value_ok = 1'b0;
		if (seqlen_q == usd_pkg::Len3 && merged < usd_pkg::Min4Byte) value_ok = 1'b0;
		if (merged > usd_pkg::MaxCp) value_ok = 1'b0;
		if (merged >= usd_pkg::SurrLow && merged <= usd_pkg::SurrHigh) value_ok = 1'b0;
	end

	always_comb begin
		partial_d = partial_q;
		pending_d = pending_q;
		seqlen_d  = seqlen_q;
		failed_d  = failed_q;
		err       = 1'b0;
		done      = 1'b0;
		cp        = '0;
		res       = '0;

		if (failed_q) begin
			if (beat.last_byte) begin
				failed_d = 1'b0;
				res.valid            = 1'b1;
				res.beat.invalid     = 1'b1;
				res.beat.end_of_text = 1'b1;
			end
		end else begin
			if (pending_q == 2'd0) begin
				priority if (b[7] == 1'b0) begin
					cp   = {13'd0, b};
					done = 1'b1;
				end else if ((b & usd_pkg::Lead2Mask) == usd_pkg::Lead2Match) begin
					partial_d = {16'd0, b[4:0]};
					pending_d = usd_pkg::Len1;
					seqlen_d  = usd_pkg::Len1;
				end else if ((b & usd_pkg::Lead3Mask) == usd_pkg::Lead3Match) begin
					partial_d = {17'd0, b[3:0]};
					pending_d = usd_pkg::Len2;
					seqlen_d  = usd_pkg::Len2;
				end else if ((b & usd_pkg::Lead4Mask) == usd_pkg::Lead4Match) begin
					partial_d = {18'd0, b[2:0]};
					pending_d = usd_pkg::Len3;
					seqlen_d  = usd_pkg::Len3;
				end else begin
					err = 1'b1;
				end
			end else if ((b & usd_pkg::ContMask) != usd_pkg::ContMatch) begin
				err = 1'b1;
			end else begin
				partial_d = merged;
				pending_d = pend_dec;
				if (pend_dec == 2'd0) begin
					if (value_ok) begin
						cp   = merged;
						done = 1'b1;
					end else begin
						err = 1'b1;
					end
					partial_d = '0;
					seqlen_d  = '0;
				end
			end

			if (beat.last_byte) begin
				// end of text: everything back to reset values
				partial_d = '0;
				pending_d = '0;
				seqlen_d  = '0;
				failed_d  = 1'b0;
				res.valid            = 1'b1;
				res.beat.end_of_text = 1'b1;
				if (!err && done) begin
					res.beat.code_point = cp;
					res.beat.has_char   = 1'b1;
				end else begin
					res.beat.invalid = 1'b1;
				end
			end else if (err) begin
				partial_d = '0;
				pending_d = '0;
				seqlen_d  = '0;
				failed_d  = 1'b1;
				res.valid        = 1'b1;
				res.beat.invalid = 1'b1;
			end else if (done) begin
				res.valid           = 1'b1;
				res.beat.code_point = cp;
				res.beat.has_char   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= '0;
			seqlen_q  <= '0;
			failed_q  <= 1'b0;
		end else if (step) begin
			partial_q <= partial_d;
			pending_q <= pending_d;
			seqlen_q  <= seqlen_d;
			failed_q  <= failed_d;
		end
	end

endmodule

[sv/usd_out_reg.sv]
// usd_out_reg: result register on the character channel
// depends on usd_pkg
module usd_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  usd_pkg::char_beat_t load_beat,
	output logic                free,
	output logic                char_valid,
	input  logic                char_stall,
	output usd_pkg::char_beat_t char_beat
);

	logic                valid_q;
	usd_pkg::char_beat_t beat_q;

	assign free       = !valid_q || !char_stall;
	assign char_valid = valid_q;
	assign char_beat  = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!char_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_q <= load_beat;
		end
	end

endmodule

[sv/utf8_strict_decoder.sv]
// utf8_strict_decoder: strict utf-8 byte stream to code point decoder
// an accepted byte waits in stage 1, then its result loads the result register, from which the char side takes it
// throughput: one byte per cycle, sustained while the character side does not stall
// bytes that complete no character and raise no error pass through with no result beat
// reset: arst_n clears both valid bits and the sequence state; payload regs are not reset
// depends on usd_pkg, usd_core, usd_out_reg
module utf8_strict_decoder (
	input  logic                clk,
	input  logic                arst_n,
	// byte channel
	input  logic                byte_valid,
	output logic                byte_stall,
	input  usd_pkg::byte_beat_t byte_beat,
	// character channel
	output logic                char_valid,
	input  logic                char_stall,
	output usd_pkg::char_beat_t char_beat
);

	// input register stage
	logic                valid_s1;
	usd_pkg::byte_beat_t beat_s1;

	usd_pkg::usd_res_t   res;
	logic                out_free;
	logic                fire_s1;
	logic                take;

	// a byte leaves stage 1 if it makes no result beat or the result register has room
	assign fire_s1    = valid_s1 && (!res.valid || out_free);
	// stage 1 takes a new beat when empty or draining this cycle
	assign byte_stall = valid_s1 && !fire_s1;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			beat_s1 <= byte_beat;
		end
	end

	// decode: state advances only when the byte actually leaves stage 1
	usd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire_s1),
		.beat   (beat_s1),
		.res    (res)
	);

	// result register toward the character side
	usd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (fire_s1 && res.valid),
		.load_beat  (res.beat),
		.free       (out_free),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat)
	);

endmodule

[tb/utf8_strict_decoder_tb.sv]
`timescale 1ns / 100ps
// utf8_strict_decoder_tb: self-checking bench for the strict utf-8 byte decoder
// a directed byte table, then random texts, every char beat checked against a typed row or a built-in decoder
// depends on usd_pkg and utf8_strict_decoder
module utf8_strict_decoder_tb;

	localparam int CpWidth = usd_pkg::CpWidth;

	// live bytes to reach by the end of the random part, the calm tail at its end, watchdog limit
	localparam int RandItems  = 1500;
	localparam int TailItems  = 150;
	localparam int QuietLimit = 500;
	localparam int DirRows    = 25;

	// how a table row is checked
	typedef enum logic [1:0] {
		ROW_PREDICT, // expectation comes from the decoder model below
		ROW_QUIET,   // no char beat may follow this byte
		ROW_TYPED    // expectation typed into the row
	} row_kind_e;

	// ways a random text is broken
	typedef enum logic [2:0] {
		FLAW_NOISE,
		FLAW_OVERLONG,
		FLAW_SURROGATE,
		FLAW_TOO_BIG,
		FLAW_CUT,
		FLAW_STRAY
	} flaw_e;

	typedef struct packed {
		logic [7:0]         data_byte;
		logic               last_byte;
		row_kind_e          kind;
		logic [CpWidth-1:0] code_point;
		logic               has_char;
		logic               invalid;
		logic               end_of_text;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                byte_valid = 1'b0;
	logic                byte_stall;
	usd_pkg::byte_beat_t byte_beat  = '0;
	logic                char_valid;
	logic                char_stall = 1'b0;
	usd_pkg::char_beat_t char_beat;

	utf8_strict_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// decoder model state, cleared at the start and after every last byte
	logic [CpWidth-1:0] acc_value   = '0;
	logic [1:0]         cont_left   = '0;
	logic [1:0]         seq_len     = '0;
	bit                 text_failed = 1'b0;

	// char beats still owed by the block, oldest first
	usd_pkg::char_beat_t pending_chars[$];

	// bytes of the random text being sent
	logic [7:0] text_bytes[$];

	dir_row_t byte_table[DirRows];

	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	int stall_left = 0;

	int fail_count = 0;
	int live_bytes = 0;
	int texts_done = 0;
	int bad_texts  = 0;
	int chars_made = 0;

	// one decode step on an accepted byte; returns 1 when a char beat is due
	function automatic bit decode_step(input usd_pkg::byte_beat_t b,
			output usd_pkg::char_beat_t r);
		logic [7:0]         d;
		logic [CpWidth-1:0] cp;
		bit                 bad;
		bit                 got_char;
		d        = b.data_byte;
		cp       = '0;
		bad      = 1'b0;
		got_char = 1'b0;
		r        = '0;
		// a failed text stays silent until its last byte
		if (text_failed) begin
			if (b.last_byte) begin
				text_failed   = 1'b0;
				r.invalid     = 1'b1;
				r.end_of_text = 1'b1;
				return 1'b1;
			end
			return 1'b0;
		end
		if (cont_left == 2'd0) begin
			// expecting a lead byte
			if (!d[7]) begin
				cp       = CpWidth'(d);
				got_char = 1'b1;
			end else if ((d & usd_pkg::Lead2Mask) == usd_pkg::Lead2Match) begin
				acc_value = CpWidth'(d[4:0]);
				cont_left = usd_pkg::Len1;
				seq_len   = usd_pkg::Len1;
			end else if ((d & usd_pkg::Lead3Mask) == usd_pkg::Lead3Match) begin
				acc_value = CpWidth'(d[3:0]);
				cont_left = usd_pkg::Len2;
				seq_len   = usd_pkg::Len2;
			end else if ((d & usd_pkg::Lead4Mask) == usd_pkg::Lead4Match) begin
				acc_value = CpWidth'(d[2:0]);
				cont_left = usd_pkg::Len3;
				seq_len   = usd_pkg::Len3;
			end else begin
				bad = 1'b1;
			end
		end else if ((d & usd_pkg::ContMask) != usd_pkg::ContMatch) begin
			// a bad continuation is an error, never a new lead
			bad = 1'b1;
		end else begin
			acc_value = {acc_value[CpWidth-7:0], d[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				// overlong, surrogate and out-of-range values are rejected
				bad = (seq_len == usd_pkg::Len1 && acc_value < usd_pkg::Min2Byte)
					|| (seq_len == usd_pkg::Len2 && acc_value < usd_pkg::Min3Byte)
					|| (seq_len == usd_pkg::Len3 && acc_value < usd_pkg::Min4Byte)
					|| acc_value > usd_pkg::MaxCp
					|| (acc_value >= usd_pkg::SurrLow && acc_value <= usd_pkg::SurrHigh);
				got_char  = !bad;
				cp        = acc_value;
				acc_value = '0;
				seq_len   = '0;
			end
		end
		if (b.last_byte) begin
			// last byte always answers; a cut-off sequence is invalid
			acc_value     = '0;
			cont_left     = '0;
			seq_len       = '0;
			r.end_of_text = 1'b1;
			if (!bad && got_char) begin
				r.code_point = cp;
				r.has_char   = 1'b1;
			end else begin
				r.invalid = 1'b1;
			end
			return 1'b1;
		end
		if (bad) begin
			acc_value   = '0;
			cont_left   = '0;
			seq_len     = '0;
			text_failed = 1'b1;
			r.invalid   = 1'b1;
			return 1'b1;
		end
		if (got_char) begin
			r.code_point = cp;
			r.has_char   = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// append one byte to the text being built
	function automatic void add_byte(input logic [7:0] v);
		text_bytes.insert(text_bytes.size(), v);
	endfunction

	// book one char beat the block still owes
	function automatic void owe_char(input usd_pkg::char_beat_t c);
		pending_chars.insert(pending_chars.size(), c);
	endfunction

	// append cp as an nb-byte sequence, legal or not
	function automatic void encode_cp(input logic [CpWidth-1:0] cp, input int nb);
		case (nb)
			1: add_byte({1'b0, cp[6:0]});
			2: begin
				add_byte({3'b110, cp[10:6]});
				add_byte({2'b10, cp[5:0]});
			end
			3: begin
				add_byte({4'b1110, cp[15:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
			default: begin
				add_byte({5'b11110, cp[20:18]});
				add_byte({2'b10, cp[17:12]});
				add_byte({2'b10, cp[11:6]});
				add_byte({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// append a random legal character of nb bytes
	function automatic void add_char(input int nb);
		logic [CpWidth-1:0] cp;
		case (nb)
			1: cp = CpWidth'($urandom_range(0, 'h7F));
			2: cp = CpWidth'($urandom_range('h80, 'h7FF));
			3: begin
				// skip over the surrogate block
				cp = CpWidth'($urandom_range('h800, 'hF7FF));
				if (cp >= usd_pkg::SurrLow)
					cp = cp + 21'h800;
			end
			default: cp = CpWidth'($urandom_range('h10000, 'h10FFFF));
		endcase
		encode_cp(cp, nb);
	endfunction

	// mostly well-formed texts; the rest carry one flaw among legal chars
	function automatic void build_text();
		flaw_e flaw;
		int    nb;
		text_bytes.delete();
		if ($urandom_range(0, 99) < 80) begin
			repeat ($urandom_range(1, 10))
				add_char($urandom_range(1, 4));
			return;
		end
		repeat ($urandom_range(0, 5))
			add_char($urandom_range(1, 4));
		flaw = flaw_e'($urandom_range(0, 5));
		case (flaw)
			FLAW_NOISE: add_byte(8'($urandom_range(0, 255)));
			FLAW_OVERLONG: begin
				nb = $urandom_range(2, 4);
				case (nb)
					2:       encode_cp(CpWidth'($urandom_range(0, 'h7F)), nb);
					3:       encode_cp(CpWidth'($urandom_range(0, 'h7FF)), nb);
					default: encode_cp(CpWidth'($urandom_range(0, 'hFFFF)), nb);
				endcase
			end
			FLAW_SURROGATE: encode_cp(CpWidth'($urandom_range('hD800, 'hDFFF)), 3);
			FLAW_TOO_BIG:   encode_cp(CpWidth'($urandom_range('h110000, 'h1FFFFF)), 4);
			FLAW_CUT: begin
				// drop at least one continuation byte
				nb = $urandom_range(2, 4);
				add_char(nb);
				repeat ($urandom_range(1, nb - 1))
					void'(text_bytes.pop_back());
			end
			default: begin
				if ($urandom_range(0, 1))
					add_byte(8'($urandom_range('h80, 'hBF)));
				else
					add_byte(8'($urandom_range('hF8, 'hFF)));
			end
		endcase
		repeat ($urandom_range(0, 3))
			add_char($urandom_range(1, 4));
	endfunction

	// put one byte beat on the channel, hold it until taken, then book the expectation
	task automatic send_byte(input usd_pkg::byte_beat_t b, input row_kind_e kind,
			input usd_pkg::char_beat_t typed);
		usd_pkg::char_beat_t r;
		bit                  made;
		if (tx_idle_on && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		// bytes of an already failed text are ignored by the block but for its last; none of them is counted
		if (!text_failed)
			live_bytes++;
		made = decode_step(b, r);
		if (made && r.end_of_text) begin
			texts_done++;
			if (r.invalid)
				bad_texts++;
		end
		if (made && r.has_char)
			chars_made++;
		if (kind == ROW_TYPED)
			owe_char(typed);
		else if (kind == ROW_PREDICT && made)
			owe_char(r);
	endtask

	// receiver: random stall bursts while enabled
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			char_stall <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 16);
			char_stall <= 1'b1;
		end
	end

	// every accepted char beat against the oldest expectation
	always @(posedge clk) begin : char_check
		usd_pkg::char_beat_t want;
		bit                  wrong;
		if (arst_n && char_valid === 1'b1 && char_stall === 1'b0) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: char beat with nothing expected, actual %p", $time, char_beat);
				fail_count++;
			end else begin
				want  = pending_chars.pop_front();
				wrong = 1'b0;
				if (char_beat.code_point !== want.code_point) begin
					$display("%0t: code_point expected %h, actual %h", $time,
						want.code_point, char_beat.code_point);
					wrong = 1'b1;
				end
				if (char_beat.has_char !== want.has_char) begin
					$display("%0t: has_char expected %b, actual %b", $time,
						want.has_char, char_beat.has_char);
					wrong = 1'b1;
				end
				if (char_beat.invalid !== want.invalid) begin
					$display("%0t: invalid expected %b, actual %b", $time,
						want.invalid, char_beat.invalid);
					wrong = 1'b1;
				end
				if (char_beat.end_of_text !== want.end_of_text) begin
					$display("%0t: end_of_text expected %b, actual %b", $time,
						want.end_of_text, char_beat.end_of_text);
					wrong = 1'b1;
				end
				if (wrong)
					fail_count++;
			end
		end
	end

	// watchdog: too long with no beat on either channel ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((byte_valid && !byte_stall) || (char_valid === 1'b1 && !char_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("utf8_strict_decoder_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		usd_pkg::byte_beat_t b;
		usd_pkg::char_beat_t typed;
		int                  text_count;
		arst_n = 1'b0;

		// data, last, check, then the typed code_point, has_char, invalid, end_of_text
		byte_table = '{
			// valid text: ascii extremes, smallest 2-byte, largest code point on the last byte
			'{8'h00, 1'b0, ROW_TYPED,   21'h00000, 1'b1, 1'b0, 1'b0},
			'{8'h7F, 1'b0, ROW_TYPED,   21'h0007F, 1'b1, 1'b0, 1'b0},
			'{8'hC2, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h80, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'hF4, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h8F, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'hBF, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'hBF, 1'b1, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			// bad lead byte as the last byte
			'{8'hF8, 1'b1, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b1},
			// stray continuation mid-text, silence, then the failed text ends
			'{8'h80, 1'b0, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b0},
			'{8'h41, 1'b0, ROW_QUIET,   21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h00, 1'b1, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b1},
			// bad continuation on the last byte
			'{8'hC2, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h41, 1'b1, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b1},
			// overlong two-byte nul
			'{8'hC0, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h80, 1'b0, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b0},
			'{8'hFF, 1'b1, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b1},
			// surrogate completed by the last byte
			'{8'hED, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'hA0, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h80, 1'b1, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b1},
			// one above the largest code point
			'{8'hF4, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h90, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h80, 1'b0, ROW_PREDICT, 21'h0,     1'b0, 1'b0, 1'b0},
			'{8'h80, 1'b1, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b1},
			// sequence cut off by the end of the text
			'{8'hE2, 1'b1, ROW_TYPED,   21'h0,     1'b0, 1'b1, 1'b1}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back with no idling on the byte side
		for (int i = 0; i < DirRows; i++) begin
			b.data_byte       = byte_table[i].data_byte;
			b.last_byte       = byte_table[i].last_byte;
			typed.code_point  = byte_table[i].code_point;
			typed.has_char    = byte_table[i].has_char;
			typed.invalid     = byte_table[i].invalid;
			typed.end_of_text = byte_table[i].end_of_text;
			send_byte(b, byte_table[i].kind, typed);
		end

		// random texts; idling switched per text, none in the tail
		text_count = 0;
		while (live_bytes < RandItems) begin
			build_text();
			tx_idle_on  = live_bytes < RandItems - TailItems && $urandom_range(0, 3) != 0;
			rx_idle_on <= live_bytes < RandItems - TailItems && $urandom_range(0, 3) != 0;
			// now and then hold the byte side until every owed beat is out
			if (text_count % 40 == 20) begin
				byte_valid <= 1'b0;
				while (pending_chars.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			for (int i = 0; i < text_bytes.size(); i++) begin
				b.data_byte = text_bytes[i];
				b.last_byte = (i == text_bytes.size() - 1);
				send_byte(b, ROW_PREDICT, '0);
			end
			text_count++;
		end

		// drain, then idle on to catch any stray beat
		byte_valid <= 1'b0;
		rx_idle_on <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d texts, %0d of them rejected, %0d characters decoded",
			texts_done, bad_texts, chars_made);
		$display("from %0d bytes the decoder acted on, with stalls and gaps on both sides",
			live_bytes);
		if (fail_count == 0)
			$display("utf8_strict_decoder_tb: PASS");
		else
			$display("utf8_strict_decoder_tb: FAIL");
		$finish;
	end

endmodule

[files.f]
sv/usd_pkg.sv
sv/usd_core.sv
sv/usd_out_reg.sv
sv/utf8_strict_decoder.sv
tb/utf8_strict_decoder_tb.sv
